/* rtl/grd_pkg.sv */
package grd_pkg;

  localparam int POS_W       = 20;
  localparam int IDX_W       = 4;
  localparam int SPACING_W   = 12;
  localparam int COUNT_W     = 4;
  localparam int OUT_W       = 22;
  localparam int ROADS       = 15;
  localparam int FRACTION_BITS_DEFAULT = 4;

  localparam logic [IDX_W-1:0]     NO_ROAD     = 4'd15;
  localparam logic [OUT_W-1:0]     OUT_MAX     = 22'h3FFFFF;
  localparam logic [SPACING_W-1:0] SPACING_RST = 12'd100;
  localparam logic [COUNT_W-1:0]   COUNT_RST   = 4'd15;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_A_OFF = 2'd1,
    ST_B_OFF = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    CFG_SPACING = 2'd0,
    CFG_VCOUNT  = 2'd1,
    CFG_HCOUNT  = 2'd2
  } cfg_index_t;

  // Control that travels beside each request through the pipeline.
  typedef struct packed {
    logic    valid;
    logic    detour;
    status_t status;
  } item_ctrl_t;

endpackage

/* rtl/grd_front.sv */
module grd_front #(
  parameter int FRACTION_BITS = grd_pkg::FRACTION_BITS_DEFAULT
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  input  logic [grd_pkg::POS_W-1:0]              a_pos_x,
  input  logic [grd_pkg::POS_W-1:0]              a_pos_y,
  input  logic [grd_pkg::IDX_W-1:0]              a_road_x,
  input  logic [grd_pkg::IDX_W-1:0]              a_road_y,
  input  logic [grd_pkg::POS_W-1:0]              b_pos_x,
  input  logic [grd_pkg::POS_W-1:0]              b_pos_y,
  input  logic [grd_pkg::IDX_W-1:0]              b_road_x,
  input  logic [grd_pkg::IDX_W-1:0]              b_road_y,
  input  logic [grd_pkg::SPACING_W-1:0]          spacing,
  input  logic [grd_pkg::COUNT_W-1:0]            vcount,
  input  logic [grd_pkg::COUNT_W-1:0]            hcount,
  output grd_pkg::item_ctrl_t                    ctrl,
  output logic [grd_pkg::COUNT_W-1:0]            count,
  output logic [(((grd_pkg::IDX_W + grd_pkg::SPACING_W + FRACTION_BITS) > grd_pkg::POS_W) ?
                 (grd_pkg::IDX_W + grd_pkg::SPACING_W + FRACTION_BITS) : grd_pkg::POS_W)-1:0]
                                                 pa, pb, other, leg1,
  output logic [(((grd_pkg::IDX_W + grd_pkg::SPACING_W + FRACTION_BITS) > grd_pkg::POS_W) ?
                 (grd_pkg::IDX_W + grd_pkg::SPACING_W + FRACTION_BITS) : grd_pkg::POS_W):0]
                                                 leg2,
  output logic [(((grd_pkg::IDX_W + grd_pkg::SPACING_W + FRACTION_BITS) > grd_pkg::POS_W) ?
                 (grd_pkg::IDX_W + grd_pkg::SPACING_W + FRACTION_BITS) : grd_pkg::POS_W)-1:0]
                                                 dist_a [grd_pkg::ROADS],
                                                 dist_b [grd_pkg::ROADS],
                                                 coord  [grd_pkg::ROADS]
);
  import grd_pkg::*;

  localparam int CW = IDX_W + SPACING_W + FRACTION_BITS;
  localparam int DW = (CW > POS_W) ? CW : POS_W;
  localparam int LW = DW + 1;

  function automatic logic [DW-1:0] road_at(logic [IDX_W-1:0] idx,
                                            logic [SPACING_W-1:0] sp);
    logic [IDX_W+SPACING_W-1:0] p;
    p = (IDX_W+SPACING_W)'(idx) * (IDX_W+SPACING_W)'(sp);
    return DW'(p) << FRACTION_BITS;
  endfunction

  function automatic logic [DW-1:0] absdiff(logic [DW-1:0] x, logic [DW-1:0] y);
    return (x > y) ? x - y : y - x;
  endfunction

  logic            a_off, b_off, use_first_l;
  logic [DW-1:0]   ax, ay, bx, by, dx, dy, m1, m2, t1, t2;
  logic [DW-1:0]   pa_next, pb_next, other_next, leg1_next;
  logic [LW-1:0]   leg2_next;
  logic [COUNT_W-1:0] count_next;
  item_ctrl_t      ctrl_next;
  logic [DW-1:0]   crd [ROADS];
  logic [DW-1:0]   da  [ROADS];
  logic [DW-1:0]   db  [ROADS];

  always_comb begin
    ax = DW'(a_pos_x);
    ay = DW'(a_pos_y);
    bx = DW'(b_pos_x);
    by = DW'(b_pos_y);
    dx = absdiff(ax, bx);
    dy = absdiff(ay, by);
    a_off = (a_road_x == NO_ROAD) && (a_road_y == NO_ROAD);
    b_off = (b_road_x == NO_ROAD) && (b_road_y == NO_ROAD);
    // The corner at (B vertical, A horizontal) takes priority over the other corner.
    use_first_l = (a_road_y != NO_ROAD) && (b_road_x != NO_ROAD);
    m1 = road_at(use_first_l ? b_road_x : b_road_y, spacing);
    m2 = road_at(use_first_l ? a_road_y : a_road_x, spacing);
    t1 = absdiff(m1, use_first_l ? ax : ay);
    t2 = absdiff(m2, use_first_l ? by : bx);

    ctrl_next.valid  = in_valid;
    ctrl_next.detour = 1'b0;
    ctrl_next.status = ST_OK;
    leg1_next  = '0;
    leg2_next  = '0;
    pa_next    = ax;
    pb_next    = bx;
    count_next = vcount;
    other_next = dy;

    if (a_off) begin
      ctrl_next.status = ST_A_OFF;
    end else if (b_off) begin
      ctrl_next.status = ST_B_OFF;
    end else if ((a_road_x == b_road_x) && (a_road_x != NO_ROAD)) begin
      leg1_next = dy;
    end else if ((a_road_y == b_road_y) && (a_road_y != NO_ROAD)) begin
      leg1_next = dx;
    end else if (use_first_l || ((a_road_x != NO_ROAD) && (b_road_y != NO_ROAD))) begin
      leg1_next = t1;
      leg2_next = LW'(t2);
    end else if ((a_road_x == NO_ROAD) && (b_road_x == NO_ROAD)) begin
      ctrl_next.detour = 1'b1;
    end else begin
      ctrl_next.detour = 1'b1;
      pa_next    = ay;
      pb_next    = by;
      count_next = hcount;
      other_next = dx;
    end

    for (int i = 0; i < ROADS; i++) begin
      crd[i] = road_at(IDX_W'(i), spacing);
      da[i]  = absdiff(crd[i], pa_next);
      db[i]  = absdiff(crd[i], pb_next);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl <= '0;
    end else begin
      ctrl <= ctrl_next;
    end
    count <= count_next;
    pa    <= pa_next;
    pb    <= pb_next;
    other <= other_next;
    leg1  <= leg1_next;
    leg2  <= leg2_next;
    for (int i = 0; i < ROADS; i++) begin
      dist_a[i] <= da[i];
      dist_b[i] <= db[i];
      coord[i]  <= crd[i];
    end
  end

endmodule

/* rtl/grd_argmin.sv */
module grd_argmin #(
  parameter int FRACTION_BITS = grd_pkg::FRACTION_BITS_DEFAULT
) (
  input  logic                        clk,
  input  logic                        rst,
  input  grd_pkg::item_ctrl_t         ctrl_in,
  input  logic [grd_pkg::COUNT_W-1:0] count,
  input  logic [(((grd_pkg::IDX_W + grd_pkg::SPACING_W + FRACTION_BITS) > grd_pkg::POS_W) ?
                 (grd_pkg::IDX_W + grd_pkg::SPACING_W + FRACTION_BITS) : grd_pkg::POS_W)-1:0]
                                      dist_a [grd_pkg::ROADS],
                                      dist_b [grd_pkg::ROADS],
                                      coord  [grd_pkg::ROADS],
  output grd_pkg::item_ctrl_t         ctrl_out,
  output logic [(((grd_pkg::IDX_W + grd_pkg::SPACING_W + FRACTION_BITS) > grd_pkg::POS_W) ?
                 (grd_pkg::IDX_W + grd_pkg::SPACING_W + FRACTION_BITS) : grd_pkg::POS_W)-1:0]
                                      ca, da, cb, db
);
  import grd_pkg::*;

  localparam int CW = IDX_W + SPACING_W + FRACTION_BITS;
  localparam int DW = (CW > POS_W) ? CW : POS_W;
  localparam int GS = 4;
  localparam int NG = (ROADS + GS - 1) / GS;

  // First level: running minimum inside each group of four roads.
  logic          gva_next [NG], gvb_next [NG];
  logic [DW-1:0] gda_next [NG], gca_next [NG], gdb_next [NG], gcb_next [NG];
  logic [DW-1:0] gda [NG], gca [NG], gdb [NG], gcb [NG];
  logic          gva [NG], gvb [NG];
  item_ctrl_t    ctrl_mid;

  always_comb begin
    for (int g = 0; g < NG; g++) begin
      gva_next[g] = 1'b0;
      gvb_next[g] = 1'b0;
      gda_next[g] = '0;
      gca_next[g] = '0;
      gdb_next[g] = '0;
      gcb_next[g] = '0;
      for (int k = 0; k < GS; k++) begin
        if ((g * GS + k) < ROADS) begin
          if (((g * GS + k) == 0) || ((g * GS + k) < int'(count))) begin
            if (!gva_next[g] || (dist_a[g * GS + k] <= gda_next[g])) begin
              gva_next[g] = 1'b1;
              gda_next[g] = dist_a[g * GS + k];
              gca_next[g] = coord[g * GS + k];
            end
            if (!gvb_next[g] || (dist_b[g * GS + k] <= gdb_next[g])) begin
              gvb_next[g] = 1'b1;
              gdb_next[g] = dist_b[g * GS + k];
              gcb_next[g] = coord[g * GS + k];
            end
          end
        end
      end
    end
  end

  // Second level: groups in index order, so later groups win ties.
  logic          fa, fb;
  logic [DW-1:0] ca_next, da_next, cb_next, db_next;

  always_comb begin
    fa = 1'b0;
    fb = 1'b0;
    ca_next = '0;
    da_next = '0;
    cb_next = '0;
    db_next = '0;
    for (int g = 0; g < NG; g++) begin
      if (gva[g] && (!fa || (gda[g] <= da_next))) begin
        fa = 1'b1;
        da_next = gda[g];
        ca_next = gca[g];
      end
      if (gvb[g] && (!fb || (gdb[g] <= db_next))) begin
        fb = 1'b1;
        db_next = gdb[g];
        cb_next = gcb[g];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl_mid <= '0;
      ctrl_out <= '0;
    end else begin
      ctrl_mid <= ctrl_in;
      ctrl_out <= ctrl_mid;
    end
    for (int g = 0; g < NG; g++) begin
      gva[g] <= gva_next[g];
      gvb[g] <= gvb_next[g];
      gda[g] <= gda_next[g];
      gca[g] <= gca_next[g];
      gdb[g] <= gdb_next[g];
      gcb[g] <= gcb_next[g];
    end
    ca <= ca_next;
    da <= da_next;
    cb <= cb_next;
    db <= db_next;
  end

endmodule

/* rtl/grd_back.sv */
module grd_back #(
  parameter int FRACTION_BITS = grd_pkg::FRACTION_BITS_DEFAULT
) (
  input  logic                      clk,
  input  logic                      rst,
  input  grd_pkg::item_ctrl_t       ctrl,
  input  logic [(((grd_pkg::IDX_W + grd_pkg::SPACING_W + FRACTION_BITS) > grd_pkg::POS_W) ?
                 (grd_pkg::IDX_W + grd_pkg::SPACING_W + FRACTION_BITS) : grd_pkg::POS_W)-1:0]
                                    ca, da, cb, db, pa, pb, other, leg1,
  input  logic [(((grd_pkg::IDX_W + grd_pkg::SPACING_W + FRACTION_BITS) > grd_pkg::POS_W) ?
                 (grd_pkg::IDX_W + grd_pkg::SPACING_W + FRACTION_BITS) : grd_pkg::POS_W):0]
                                    leg2,
  output logic                      done,
  output logic [grd_pkg::OUT_W-1:0] road_distance,
  output logic [grd_pkg::OUT_W-1:0] first_leg,
  output logic [grd_pkg::OUT_W-1:0] second_leg,
  output logic [1:0]                status
);
  import grd_pkg::*;

  localparam int CW = IDX_W + SPACING_W + FRACTION_BITS;
  localparam int DW = (CW > POS_W) ? CW : POS_W;
  localparam int LW = DW + 1;

  function automatic logic [DW-1:0] absdiff(logic [DW-1:0] x, logic [DW-1:0] y);
    return (x > y) ? x - y : y - x;
  endfunction

  function automatic logic [OUT_W-1:0] sat(logic [LW:0] x);
    return (x > (LW+1)'(OUT_MAX)) ? OUT_MAX : OUT_W'(x);
  endfunction

  // Cost of each candidate cross road.
  item_ctrl_t    c5;
  logic [DW-1:0] xa, xb, da5, db5, other5, leg1_5;
  logic [LW-1:0] leg2_5, cost_a, cost_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      c5 <= '0;
    end else begin
      c5 <= ctrl;
    end
    xa     <= absdiff(ca, pb);
    xb     <= absdiff(cb, pa);
    cost_a <= LW'(da) + LW'(absdiff(ca, pb));
    cost_b <= LW'(db) + LW'(absdiff(cb, pa));
    da5    <= da;
    db5    <= db;
    other5 <= other;
    leg1_5 <= leg1;
    leg2_5 <= leg2;
  end

  // A's candidate is taken only when strictly cheaper.
  item_ctrl_t    c6;
  logic          pick_a;
  logic [DW-1:0] leg1_6_next, part;
  logic [LW-1:0] leg2_6_next;
  logic [DW-1:0] leg1_6;
  logic [LW-1:0] leg2_6;

  always_comb begin
    pick_a = cost_a < cost_b;
    part   = pick_a ? xa : db5;
    if (c5.detour) begin
      leg1_6_next = pick_a ? da5 : xb;
      leg2_6_next = LW'(part) + LW'(other5);
    end else begin
      leg1_6_next = leg1_5;
      leg2_6_next = leg2_5;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c6 <= '0;
    end else begin
      c6 <= c5;
    end
    leg1_6 <= leg1_6_next;
    leg2_6 <= leg2_6_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= c6.valid;
    end
    road_distance <= sat((LW+1)'(leg1_6) + (LW+1)'(leg2_6));
    first_leg     <= sat((LW+1)'(leg1_6));
    second_leg    <= sat((LW+1)'(leg2_6));
    status        <= c6.status;
  end

endmodule

/* rtl/grid_road_distance.sv */
// Road distance between two points on a street grid. A request is taken at every
// rising edge where start is high; busy is always low, so a new point pair may be
// issued in every cycle. Each request produces exactly one result, shown for one
// cycle with done high once it has passed every register stage; results leave
// in request order and the receiver cannot stall them, so it must capture each
// result in the cycle that done is high. The pipeline has seven register stages:
// input capture, classification with all candidate road distances, two levels of
// the nearest-road tree, cost of the two cross-road candidates, path selection,
// and summing with saturation. The configuration channel always accepts (cfg_ready
// is high); write it only while no request is in flight, since the registers feed
// the second stage directly.
module grid_road_distance #(
  parameter int FRACTION_BITS = grd_pkg::FRACTION_BITS_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [grd_pkg::POS_W-1:0]     a_pos_x,
  input  logic [grd_pkg::POS_W-1:0]     a_pos_y,
  input  logic [grd_pkg::IDX_W-1:0]     a_road_x,
  input  logic [grd_pkg::IDX_W-1:0]     a_road_y,
  input  logic [grd_pkg::POS_W-1:0]     b_pos_x,
  input  logic [grd_pkg::POS_W-1:0]     b_pos_y,
  input  logic [grd_pkg::IDX_W-1:0]     b_road_x,
  input  logic [grd_pkg::IDX_W-1:0]     b_road_y,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [1:0]                    cfg_index,
  input  logic [grd_pkg::SPACING_W-1:0] cfg_data,
  output logic                          done,
  output logic [grd_pkg::OUT_W-1:0]     road_distance,
  output logic [grd_pkg::OUT_W-1:0]     first_leg,
  output logic [grd_pkg::OUT_W-1:0]     second_leg,
  output logic [1:0]                    status
);
  import grd_pkg::*;

  localparam int CW = IDX_W + SPACING_W + FRACTION_BITS;
  localparam int DW = (CW > POS_W) ? CW : POS_W;
  localparam int LW = DW + 1;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  // Configuration registers. Unknown indexes are ignored.
  logic [SPACING_W-1:0] spacing;
  logic [COUNT_W-1:0]   vcount, hcount;

  always_ff @(posedge clk) begin
    if (rst) begin
      spacing <= SPACING_RST;
      vcount  <= COUNT_RST;
      hcount  <= COUNT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index_t'(cfg_index))
        CFG_SPACING: spacing <= cfg_data;
        CFG_VCOUNT:  vcount  <= cfg_data[COUNT_W-1:0];
        CFG_HCOUNT:  hcount  <= cfg_data[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Stage one captures the request.
  logic              v1;
  logic [POS_W-1:0]  ax1, ay1, bx1, by1;
  logic [IDX_W-1:0]  arx1, ary1, brx1, bry1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= start && !busy;
    end
    ax1  <= a_pos_x;
    ay1  <= a_pos_y;
    arx1 <= a_road_x;
    ary1 <= a_road_y;
    bx1  <= b_pos_x;
    by1  <= b_pos_y;
    brx1 <= b_road_x;
    bry1 <= b_road_y;
  end

  // Stage two sorts the request into a straight, L, or detour path and measures
  // every candidate cross road against both points.
  item_ctrl_t         ctrl2, ctrl4;
  logic [COUNT_W-1:0] count2;
  logic [DW-1:0]      pa2, pb2, other2, leg1_2;
  logic [LW-1:0]      leg2_2;
  logic [DW-1:0]      dist_a [ROADS];
  logic [DW-1:0]      dist_b [ROADS];
  logic [DW-1:0]      coord  [ROADS];

  grd_front #(.FRACTION_BITS(FRACTION_BITS)) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (v1),
    .a_pos_x  (ax1),
    .a_pos_y  (ay1),
    .a_road_x (arx1),
    .a_road_y (ary1),
    .b_pos_x  (bx1),
    .b_pos_y  (by1),
    .b_road_x (brx1),
    .b_road_y (bry1),
    .spacing  (spacing),
    .vcount   (vcount),
    .hcount   (hcount),
    .ctrl     (ctrl2),
    .count    (count2),
    .pa       (pa2),
    .pb       (pb2),
    .other    (other2),
    .leg1     (leg1_2),
    .leg2     (leg2_2),
    .dist_a   (dist_a),
    .dist_b   (dist_b),
    .coord    (coord)
  );

  // Stages three and four find the nearest allowed cross road for each point.
  logic [DW-1:0] ca4, da4, cb4, db4;

  grd_argmin #(.FRACTION_BITS(FRACTION_BITS)) u_argmin (
    .clk      (clk),
    .rst      (rst),
    .ctrl_in  (ctrl2),
    .count    (count2),
    .dist_a   (dist_a),
    .dist_b   (dist_b),
    .coord    (coord),
    .ctrl_out (ctrl4),
    .ca       (ca4),
    .da       (da4),
    .cb       (cb4),
    .db       (db4)
  );

  // The point positions and precomputed legs wait beside the search tree.
  logic [DW-1:0] pa3, pb3, other3, leg1_3, pa4, pb4, other4, leg1_4;
  logic [LW-1:0] leg2_3, leg2_4;

  always_ff @(posedge clk) begin
    pa3    <= pa2;
    pb3    <= pb2;
    other3 <= other2;
    leg1_3 <= leg1_2;
    leg2_3 <= leg2_2;
    pa4    <= pa3;
    pb4    <= pb3;
    other4 <= other3;
    leg1_4 <= leg1_3;
    leg2_4 <= leg2_3;
  end

  // Stages five to seven pick the cheaper cross road and form the outputs.
  grd_back #(.FRACTION_BITS(FRACTION_BITS)) u_back (
    .clk           (clk),
    .rst           (rst),
    .ctrl          (ctrl4),
    .ca            (ca4),
    .da            (da4),
    .cb            (cb4),
    .db            (db4),
    .pa            (pa4),
    .pb            (pb4),
    .other         (other4),
    .leg1          (leg1_4),
    .leg2          (leg2_4),
    .done          (done),
    .road_distance (road_distance),
    .first_leg     (first_leg),
    .second_leg    (second_leg),
    .status        (status)
  );

endmodule

/* rtl/grd_checker.sv */
module grd_props (
  input logic                          clk,
  input logic                          rst,
  input logic                          start,
  input logic                          busy,
  input logic                          done,
  input logic [grd_pkg::OUT_W-1:0]     road_distance,
  input logic [grd_pkg::OUT_W-1:0]     first_leg,
  input logic [grd_pkg::OUT_W-1:0]     second_leg,
  input logic [1:0]                    status
);
  import grd_pkg::*;

  localparam int LATENCY = 7;

  logic [OUT_W:0] leg_sum;
  assign leg_sum = (OUT_W+1)'(first_leg) + (OUT_W+1)'(second_leg);

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##LATENCY done)
    else $error("request produced no result");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LATENCY))
    else $error("result without request");

  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    (done && (status != ST_OK)) |->
      (road_distance == '0 && first_leg == '0 && second_leg == '0))
    else $error("error result carries distance");

  a_sum: assert property (@(posedge clk) disable iff (rst)
    (done && (leg_sum < (OUT_W+1)'(OUT_MAX))) |-> (road_distance == OUT_W'(leg_sum)))
    else $error("total is not the sum of the legs");

endmodule

bind grid_road_distance grd_props u_grd_props (.*);
